### hdl/cfa_pkg.sv
// Shared types and constants for the contiguous frame allocator.
package cfa_pkg;

  localparam int FW = 20;          // absolute frame number width
  localparam int CW = 11;          // count width
  localparam int SW = FW + 1;      // range-check sum width
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam int POOL_RESET = 1024;

  // Per-frame state codes in the map
  localparam logic [1:0] FS_FREE = 2'h1;
  localparam logic [1:0] FS_USED = 2'h2;
  localparam logic [1:0] FS_HEAD = 2'h3;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_POOL = 2'd1;
  localparam logic [1:0] REG_RESV = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MARK    = 2'd2,
    OP_INIT    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_NOTHEAD = 2'd3
  } status_t;

  typedef struct packed {
    logic [FW-1:0] base_frame;
    logic [CW-1:0] pool_frames;
    logic          reserve_first;
  } cfg_t;

  typedef struct packed {
    logic    latch;
    logic    init_load;
    logic    clear;
    logic    start;
    logic    run;
    logic    fill;
    logic    set_st;
    status_t st;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic chk_bad;
    logic no_fit;
    logic hit;
    logic at_end;
    logic rel_bad;
    logic rel_stop;
    logic mark_end;
    logic fill_last;
    logic clear_done;
    logic out_free;
  } dp_sts_t;

endpackage

### hdl/contiguous_frame_allocator_top.sv
// Contiguous frame allocator: a two-bit-per-frame map of one frame pool.
// Timing: one command is in progress at a time; the map sits in a single
// memory with one write and one registered read port, walked one frame per
// cycle. Allocate scans to the first fitting run, then makes one write per
// frame; release walks the run (the walk reads one frame past the run to find
// its end); mark writes each frame of its range; init makes one clearing
// write per pool frame. After reset a clearing pass over min(1024, MAX_FRAMES)
// frames runs with s_tready low. A finished result sits in an output register,
// so the next command can be taken before m_tready is seen.
// Register writes take effect only at the next init command.
module contiguous_frame_allocator_top #(
  parameter int MAX_FRAMES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [19:0] start_frame, [30:20] count, [31] zero
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [19:0] result_frame, [30:20] free_frames, [31] zero
  output logic [1:0]  m_tuser    // [1:0] status
);
  import cfa_pkg::*;

  cfg_t          cfg;
  dp_cmd_t       cmd;
  dp_sts_t       sts;
  op_t           in_op;
  status_t       out_status;
  logic [FW-1:0] out_frame;
  logic [CW-1:0] out_free;

  assign in_op   = op_t'(s_tuser);
  assign m_tuser = out_status;
  assign m_tdata = {1'b0, out_free, out_frame};

  cfa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cfa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .in_op   (in_op),
    .sts     (sts),
    .s_ready (s_tready),
    .cmd     (cmd)
  );

  cfa_dpath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .in_op      (in_op),
    .in_fno     (s_tdata[FW-1:0]),
    .in_cnt     (s_tdata[FW+CW-1:FW]),
    .sts        (sts),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_status (out_status),
    .out_frame  (out_frame),
    .out_free   (out_free)
  );

endmodule

### hdl/cfa_regs.sv
// Configuration register file behind the APB port.
module cfa_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cfa_pkg::APB_AW-1:0] paddr,
  input  logic [cfa_pkg::APB_DW-1:0] pwdata,
  output logic [cfa_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output cfa_pkg::cfg_t             cfg
);
  import cfa_pkg::*;

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_frame    <= '0;
      cfg.pool_frames   <= CW'(POOL_RESET);
      cfg.reserve_first <= 1'b1;
    end else if (wr) begin
      unique case (idx)
        REG_BASE: cfg.base_frame    <= pwdata[FW-1:0];
        REG_POOL: cfg.pool_frames   <= pwdata[CW-1:0];
        REG_RESV: cfg.reserve_first <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE: prdata = APB_DW'(cfg.base_frame);
      REG_POOL: prdata = APB_DW'(cfg.pool_frames);
      REG_RESV: prdata = APB_DW'(cfg.reserve_first);
      default:  prdata = '0;
    endcase
  end

endmodule

### hdl/cfa_ctrl.sv
// Sequencer for the allocator: one operation at a time.
module cfa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_valid,
  input  cfa_pkg::op_t     in_op,
  input  cfa_pkg::dp_sts_t sts,
  output logic             s_ready,
  output cfa_pkg::dp_cmd_t cmd
);
  import cfa_pkg::*;

  typedef enum logic [10:0] {
    S_BOOT  = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_CLEAR = 11'b000_0000_0100,
    S_ACHK  = 11'b000_0000_1000,
    S_ASCAN = 11'b000_0001_0000,
    S_AFILL = 11'b000_0010_0000,
    S_RCHK  = 11'b000_0100_0000,
    S_RWALK = 11'b000_1000_0000,
    S_MCHK  = 11'b001_0000_0000,
    S_MSCAN = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BOOT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.st     = STAT_OK;
    s_ready    = 1'b0;
    unique case (state)
      S_BOOT: begin
        if (sts.clear_done) state_next = S_IDLE;
        else cmd.clear = 1'b1;
      end
      S_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.latch = 1'b1;
          unique case (in_op)
            OP_ALLOC:   state_next = S_ACHK;
            OP_RELEASE: state_next = S_RCHK;
            OP_MARK:    state_next = S_MCHK;
            OP_INIT: begin
              cmd.init_load = 1'b1;
              state_next    = S_CLEAR;
            end
          endcase
        end
      end
      S_CLEAR: begin
        if (sts.clear_done) state_next = S_FIN;
        else cmd.clear = 1'b1;
      end
      S_ACHK: begin
        priority if (sts.chk_bad) begin
          cmd.set_st = 1'b1;
          cmd.st     = STAT_RANGE;
          state_next = S_FIN;
        end else if (sts.no_fit) begin
          cmd.set_st = 1'b1;
          cmd.st     = STAT_NOSPACE;
          state_next = S_FIN;
        end else begin
          cmd.start  = 1'b1;
          state_next = S_ASCAN;
        end
      end
      S_ASCAN: begin
        cmd.run = 1'b1;
        priority if (sts.hit) begin
          state_next = S_AFILL;
        end else if (sts.at_end) begin
          cmd.set_st = 1'b1;
          cmd.st     = STAT_NOSPACE;
          state_next = S_FIN;
        end else begin
          state_next = S_ASCAN;
        end
      end
      S_AFILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) state_next = S_FIN;
      end
      S_RCHK, S_MCHK: begin
        if (sts.chk_bad) begin
          cmd.set_st = 1'b1;
          cmd.st     = STAT_RANGE;
          state_next = S_FIN;
        end else begin
          cmd.start  = 1'b1;
          state_next = (state == S_RCHK) ? S_RWALK : S_MSCAN;
        end
      end
      S_RWALK: begin
        cmd.run = 1'b1;
        priority if (sts.rel_bad) begin
          cmd.set_st = 1'b1;
          cmd.st     = STAT_NOTHEAD;
          state_next = S_FIN;
        end else if (sts.rel_stop || sts.at_end) begin
          state_next = S_FIN;
        end else begin
          state_next = S_RWALK;
        end
      end
      S_MSCAN: begin
        cmd.run = 1'b1;
        if (sts.mark_end) state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_BOOT;
    endcase
  end

endmodule

### hdl/cfa_dpath.sv
// Frame map memory, scan pointers, free counter and result register.
module cfa_dpath #(
  parameter int MAX_FRAMES = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfa_pkg::cfg_t         cfg,
  input  cfa_pkg::dp_cmd_t      cmd,
  input  cfa_pkg::op_t          in_op,
  input  logic [cfa_pkg::FW-1:0] in_fno,
  input  logic [cfa_pkg::CW-1:0] in_cnt,
  output cfa_pkg::dp_sts_t      sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output cfa_pkg::status_t      out_status,
  output logic [cfa_pkg::FW-1:0] out_frame,
  output logic [cfa_pkg::CW-1:0] out_free
);
  import cfa_pkg::*;

  localparam int AW = $clog2(MAX_FRAMES);
  localparam int PW = (AW + 1 > CW) ? AW + 1 : CW;
  localparam logic [PW-1:0] MAX_P   = PW'(MAX_FRAMES);
  localparam logic [PW-1:0] RST_ACT = (MAX_FRAMES < POOL_RESET) ? MAX_P : PW'(POOL_RESET);

  logic [1:0] map [MAX_FRAMES];
  logic [1:0] rdata;

  op_t           op;
  logic [FW-1:0] fno;
  logic [CW-1:0] cnt;
  logic [FW-1:0] act_base;
  logic [PW-1:0] act_frames;
  logic          act_resv;
  logic [CW-1:0] free_cnt;
  logic [PW-1:0] pos, didx, run, wpos, wend;
  logic          dv, first;
  status_t       stat;
  logic [FW-1:0] res_frame;

  logic [PW-1:0] cnt_p, idx_p, run_n, start_idx, act_new;
  logic [FW-1:0] diff;
  logic [SW-1:0] mark_sum;
  logic [CW-1:0] fc_new;
  logic          below, rel_rng_bad, mark_bad, data_free, issue, rel_wr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [1:0]    wdata;

  assign cnt_p       = PW'(cnt);
  assign diff        = fno - act_base;
  assign idx_p       = diff[PW-1:0];
  assign below       = fno < act_base;
  assign rel_rng_bad = below || (diff >= FW'(act_frames));
  assign mark_sum    = {1'b0, diff} + SW'(cnt);
  assign mark_bad    = (cnt == '0) || below || (mark_sum > SW'(act_frames));
  assign data_free   = (rdata != FS_USED) && (rdata != FS_HEAD);
  assign run_n       = data_free ? run + PW'(1) : '0;
  assign start_idx   = didx + PW'(1) - cnt_p;
  assign issue       = cmd.run && (pos < act_frames);
  assign rel_wr      = dv && (first ? (rdata == FS_HEAD) : (rdata == FS_USED));
  assign act_new     = (PW'(cfg.pool_frames) > MAX_P) ? MAX_P : PW'(cfg.pool_frames);
  assign fc_new      = CW'(act_new) - CW'(cfg.reserve_first && (act_new != '0));

  always_comb begin
    unique case (op)
      OP_ALLOC:   sts.chk_bad = (cnt == '0);
      OP_RELEASE: sts.chk_bad = rel_rng_bad;
      OP_MARK:    sts.chk_bad = mark_bad;
      OP_INIT:    sts.chk_bad = 1'b0;
    endcase
  end

  assign sts.no_fit     = cnt_p > act_frames;
  assign sts.hit        = dv && (run_n == cnt_p);
  assign sts.at_end     = dv && (didx == act_frames - PW'(1));
  assign sts.rel_bad    = dv && first && (rdata != FS_HEAD);
  assign sts.rel_stop   = dv && !first && (rdata != FS_USED);
  assign sts.mark_end   = dv && (didx == wend);
  assign sts.fill_last  = wpos == wend;
  assign sts.clear_done = pos == act_frames;
  assign sts.out_free   = !out_valid || out_ready;

  // single write port: clearing pass, allocation fill, release walk, mark scan
  always_comb begin
    we    = 1'b0;
    waddr = pos[AW-1:0];
    wdata = FS_FREE;
    priority if (cmd.clear) begin
      we    = 1'b1;
      wdata = ((pos == '0) && act_resv) ? FS_USED : FS_FREE;
    end else if (cmd.fill) begin
      we    = 1'b1;
      waddr = wpos[AW-1:0];
      wdata = first ? FS_HEAD : FS_USED;
    end else if (cmd.run && (op == OP_RELEASE)) begin
      we    = rel_wr;
      waddr = didx[AW-1:0];
    end else if (cmd.run && (op == OP_MARK)) begin
      we    = dv;
      waddr = didx[AW-1:0];
      wdata = first ? FS_HEAD : FS_USED;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) rdata <= map[pos[AW-1:0]];
    if (we) map[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_base   <= '0;
      act_frames <= RST_ACT;
      act_resv   <= 1'b1;
      free_cnt   <= CW'(RST_ACT) - CW'(1);
      pos        <= '0;
      dv         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.latch) begin
        op        <= in_op;
        fno       <= in_fno;
        cnt       <= in_cnt;
        stat      <= STAT_OK;
        res_frame <= '0;
      end
      if (cmd.init_load) begin
        act_base   <= cfg.base_frame;
        act_frames <= act_new;
        act_resv   <= cfg.reserve_first;
        free_cnt   <= fc_new;
        pos        <= '0;
      end
      if (cmd.clear) pos <= pos + PW'(1);
      if (cmd.start) begin
        pos   <= (op == OP_ALLOC) ? '0 : idx_p;
        dv    <= 1'b0;
        run   <= '0;
        first <= 1'b1;
        wend  <= idx_p + cnt_p - PW'(1);
      end
      if (cmd.run) begin
        dv   <= issue;
        didx <= pos;
        if (issue) pos <= pos + PW'(1);
        if (dv) begin
          unique case (op)
            OP_ALLOC: begin
              run <= run_n;
              if (run_n == cnt_p) begin
                wpos      <= start_idx;
                wend      <= didx;
                free_cnt  <= free_cnt - cnt;
                res_frame <= act_base + FW'(start_idx);
              end
            end
            OP_RELEASE: begin
              first <= 1'b0;
              if (rel_wr) free_cnt <= free_cnt + CW'(1);
            end
            OP_MARK: begin
              first <= 1'b0;
              if (data_free && (free_cnt != '0)) free_cnt <= free_cnt - CW'(1);
            end
            OP_INIT: ;
          endcase
        end
      end
      if (cmd.fill) begin
        wpos  <= wpos + PW'(1);
        first <= 1'b0;
      end
      if (cmd.set_st) stat <= cmd.st;
      if (cmd.out_load) begin
        out_valid  <= 1'b1;
        out_status <= stat;
        out_frame  <= res_frame;
        out_free   <= free_cnt;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/cfa_checker.sv
// Port-level checks for the allocator, bound to the top level.
module cfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import cfa_pkg::*;

  // one command at a time: no back-to-back accepts
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a command was in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed or dropped");

  // failed commands never report a frame
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != STAT_OK)) |-> (m_tdata[19:0] == 20'd0))
    else $error("nonzero result_frame on failed command");

  // reset starts the clearing pass with nothing pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !s_tready))
    else $error("block not quiet after reset");

endmodule

bind contiguous_frame_allocator_top cfa_checker u_cfa_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the contiguous frame allocator: stream commands in, check replies.
`timescale 1ns / 1ps

module tb_top;
  import cfa_pkg::*;

  localparam int MAP_DEPTH   = 1024;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int TAIL_CYCLES = 2100;

  typedef struct packed {
    status_t       status;
    logic [FW-1:0] result_frame;
    logic [CW-1:0] free_frames;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [19:0] start_frame, [30:20] count, [31] zero
  logic [1:0]  s_tuser;   // [1:0] cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [19:0] result_frame, [30:20] free_frames, [31] zero
  logic [1:0]  m_tuser;   // [1:0] status

  // Register shadows and the predicted pool
  logic [FW-1:0] reg_base;
  logic [CW-1:0] reg_pool;
  logic          reg_resv;
  logic [1:0]    pool_map [MAP_DEPTH];
  int            pool_free;
  int            pool_size;
  logic [FW-1:0] pool_base;

  outcome_t outcome_q[$];
  int       fail_count;
  int       quiet_cycles;
  bit       idle_on;
  bit       hold_req;

  contiguous_frame_allocator_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic bit frame_is_free(logic [1:0] s);
    return s != FS_USED && s != FS_HEAD;
  endfunction

  function automatic void pool_reinit();
    pool_size = (reg_pool > MAP_DEPTH) ? MAP_DEPTH : int'(reg_pool);
    pool_base = reg_base;
    for (int i = 0; i < MAP_DEPTH; i++) pool_map[i] = FS_FREE;
    pool_free = pool_size;
    if (reg_resv && pool_size > 0) begin
      pool_map[0] = FS_USED;
      pool_free--;
    end
  endfunction

  // Applies one command to the predicted pool and returns the expected reply.
  function automatic outcome_t track_cmd(op_t op, logic [FW-1:0] fno, logic [CW-1:0] cnt);
    outcome_t o;
    int run, start, f, b, idx;
    o.status = STAT_OK;
    o.result_frame = '0;
    f = fno;
    b = pool_base;
    case (op)
      OP_ALLOC: begin
        if (cnt == 0) o.status = STAT_RANGE;
        else if (cnt > pool_size) o.status = STAT_NOSPACE;
        else begin
          o.status = STAT_NOSPACE;
          run = 0;
          for (int i = 0; i < pool_size; i++) begin
            run = frame_is_free(pool_map[i]) ? run + 1 : 0;
            if (run == cnt) begin
              start = i + 1 - run;
              pool_map[start] = FS_HEAD;
              for (int k = start + 1; k <= i; k++) pool_map[k] = FS_USED;
              pool_free -= run;
              o.status = STAT_OK;
              o.result_frame = FW'(pool_base + start);
              break;
            end
          end
        end
      end
      OP_RELEASE: begin
        if (f < b || f - b >= pool_size) o.status = STAT_RANGE;
        else if (pool_map[f - b] != FS_HEAD) o.status = STAT_NOTHEAD;
        else begin
          idx = f - b;
          pool_map[idx] = FS_FREE;
          pool_free++;
          idx++;
          // walk stops at a free frame, the next head or the pool end
          while (idx < pool_size && pool_map[idx] == FS_USED) begin
            pool_map[idx] = FS_FREE;
            pool_free++;
            idx++;
          end
        end
      end
      OP_MARK: begin
        if (cnt == 0 || f < b || (f - b) + cnt > pool_size) o.status = STAT_RANGE;
        else begin
          idx = f - b;
          for (int k = idx; k < idx + cnt; k++) begin
            if (frame_is_free(pool_map[k]) && pool_free > 0) pool_free--;
            pool_map[k] = (k == idx) ? FS_HEAD : FS_USED;
          end
        end
      end
      default: pool_reinit();
    endcase
    o.free_frames = CW'(pool_free);
    return o;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_BASE: reg_base = val[FW-1:0];
      REG_POOL: reg_pool = val[CW-1:0];
      REG_RESV: reg_resv = val[0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_cmd(op_t op, logic [FW-1:0] fno, logic [CW-1:0] cnt,
                          output outcome_t got);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, cnt, fno};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    got = track_cmd(op, fno, cnt);
    outcome_q.push_back(got);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Reply checker
  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst && m_tvalid && m_tready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected reply status %0d frame %h free %0d", $time,
                 m_tuser, m_tdata[19:0], m_tdata[30:20]);
        fail_count++;
      end else begin
        exp_o = outcome_q.pop_front();
        if (m_tuser !== exp_o.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_o.status, m_tuser);
          fail_count++;
        end
        if (m_tdata[19:0] !== exp_o.result_frame) begin
          $display("%0t: result_frame expected %h got %h", $time, exp_o.result_frame,
                   m_tdata[19:0]);
          fail_count++;
        end
        if (m_tdata[30:20] !== exp_o.free_frames) begin
          $display("%0t: free_frames expected %0d got %0d", $time, exp_o.free_frames,
                   m_tdata[30:20]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on transactions of any port
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Reply sink: random stalls, plus a long hold-off on request
  initial begin : sink
    int n;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic test_directed();
    outcome_t got;
    // default config: base 0, 1024 frames, frame 0 reserved
    send_cmd(OP_ALLOC,   20'd0,       11'd0,    got);  // zero count
    send_cmd(OP_ALLOC,   20'd0,       11'd2047, got);  // larger than the pool
    send_cmd(OP_ALLOC,   20'd0,       11'd1024, got);  // full scan, no run
    send_cmd(OP_ALLOC,   20'd0,       11'd1,    got);
    send_cmd(OP_ALLOC,   20'd0,       11'd2,    got);
    send_cmd(OP_ALLOC,   20'd0,       11'd3,    got);
    send_cmd(OP_RELEASE, 20'd0,       11'd0,    got);  // reserved frame
    send_cmd(OP_RELEASE, 20'd3,       11'd0,    got);  // used, not head
    send_cmd(OP_RELEASE, 20'd100,     11'd0,    got);  // free frame
    send_cmd(OP_RELEASE, 20'd1024,    11'd0,    got);  // just past the pool
    send_cmd(OP_RELEASE, 20'hFFFFF,   11'd0,    got);
    send_cmd(OP_RELEASE, 20'd2,       11'd0,    got);  // stops at the next head
    send_cmd(OP_MARK,    20'd2,       11'd0,    got);
    send_cmd(OP_MARK,    20'd1020,    11'd5,    got);  // runs off the end
    send_cmd(OP_MARK,    20'd1,       11'd4,    got);  // partly over busy frames
    send_cmd(OP_RELEASE, 20'd1,       11'd0,    got);  // long walk over used frames
    send_cmd(OP_MARK,    20'd0,       11'd1024, got);  // whole pool from its base
    send_cmd(OP_ALLOC,   20'd0,       11'd1,    got);
    send_cmd(OP_RELEASE, 20'd0,       11'd0,    got);
    send_cmd(OP_MARK,    20'hFFFFF,   11'd2047, got);
    send_cmd(OP_ALLOC,   20'd0,       11'd1024, got);
    send_cmd(OP_INIT,    20'd0,       11'd0,    got);
    send_cmd(OP_ALLOC,   20'd0,       11'd1023, got);
    drain();
  endtask

  task automatic run_phase(logic [FW-1:0] base, logic [CW-1:0] frames, logic resv,
                           int n_items);
    outcome_t      got;
    logic [FW-1:0] live_heads[$];
    op_t           op;
    logic [FW-1:0] fno;
    logic [CW-1:0] cnt;
    int            r, k, idx, lim;
    write_reg(REG_BASE, 32'(base));
    write_reg(REG_POOL, 32'(frames));
    write_reg(REG_RESV, 32'(resv));
    // new settings must not show before init
    send_cmd(OP_ALLOC, 20'(base), 11'd1, got);
    send_cmd(OP_INIT, FW'($urandom_range(0, 20'hFFFFF)), CW'($urandom_range(0, 2047)), got);
    for (int i = 0; i < n_items; i++) begin
      r   = $urandom_range(0, 99);
      fno = FW'($urandom_range(0, 20'hFFFFF));
      cnt = CW'($urandom_range(0, 2047));
      if (r < 40 && pool_size > 0) begin
        op  = OP_ALLOC;
        lim = (pool_size < 3) ? 1 : pool_size / 3;
        cnt = ($urandom_range(0, 9) == 0) ? CW'($urandom_range(1, pool_size + 1))
                                          : CW'($urandom_range(1, lim));
      end else if (r < 76 && live_heads.size() > 0) begin
        op  = OP_RELEASE;
        k   = $urandom_range(0, live_heads.size() - 1);
        fno = live_heads[k];
        live_heads.delete(k);
      end else if (r < 86 && pool_size > 0) begin
        op  = OP_MARK;
        idx = $urandom_range(0, pool_size - 1);
        lim = (pool_size - idx > 4) ? 4 : pool_size - idx;
        cnt = CW'($urandom_range(1, lim));
        fno = FW'(pool_base + idx);
      end else if (r < 98) begin
        // broken commands: random op, near the pool edges or anywhere
        op = op_t'($urandom_range(0, 2));
        if ($urandom_range(0, 1))
          fno = FW'(pool_base + $urandom_range(0, pool_size + 2) - 1);
        if ($urandom_range(0, 1)) cnt = CW'($urandom_range(0, 6));
      end else begin
        op = OP_INIT;
      end
      send_cmd(op, fno, cnt, got);
      if (op == OP_INIT) live_heads.delete();
      else if (got.status == STAT_OK && op == OP_ALLOC) live_heads.push_back(got.result_frame);
      else if (got.status == STAT_OK && op == OP_MARK) live_heads.push_back(fno);
    end
    drain();
  endtask

  task automatic test_pool_shapes();
    idle_on = 1'b1;
    run_phase(20'd0,      11'd2047, 1'b0, 120);  // oversized, clipped to the map
    idle_on = 1'b0;
    run_phase(20'hFFFFF,  11'd16,   1'b1, 130);  // frame numbers wrap
    idle_on = 1'b1;
    run_phase(20'd0,      11'd0,    1'b1, 20);   // empty pool
    run_phase(20'd0,      11'd1,    1'b0, 40);
    run_phase(20'd0,      11'd1,    1'b1, 10);
    run_phase(FW'($urandom_range(0, 20'hFFFFF)), CW'($urandom_range(8, 64)),
              1'($urandom_range(0, 1)), 150);
    idle_on = 1'b0;
    run_phase(FW'($urandom_range(0, 20'hFFFFF)), 11'd1024, 1'b1, 120);
    idle_on = 1'b1;
    run_phase(FW'($urandom_range(0, 20'hFFFFF)), CW'($urandom_range(8, 40)),
              1'($urandom_range(0, 1)), 215);
  endtask

  task automatic test_backpressure();
    outcome_t got;
    hold_req = 1'b1;
    // sink holds off while commands keep coming, so the input must stall
    for (int i = 0; i < 8; i++)
      send_cmd(i % 3 == 2 ? OP_RELEASE : OP_ALLOC, FW'(pool_base + i), 11'd1, got);
    drain();
  endtask

  initial begin
    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tuser    <= OP_ALLOC;
    fail_count = 0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    reg_base   = '0;
    reg_pool   = CW'(POOL_RESET);
    reg_resv   = 1'b1;
    pool_reinit();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_pool_shapes();
    test_backpressure();

    while (outcome_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
